// ===== sv/ndg_pkg.sv =====
// ----------------------------------------------------------------------------
// ndg_pkg: shared types and constants
// Widths, register map, pixel and result types and the step arithmetic used
// by the nearest-neighbor gray downscaler.
// ----------------------------------------------------------------------------
package ndg_pkg;

	// largest supported frame dimension in pixels
	localparam int MAX_DIM = 4096;

	// clamped dimension (1..MAX_DIM)
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	// position inside a line or frame (0..MAX_DIM-1), also step remainders
	localparam int POS_W  = $clog2(MAX_DIM);
	// pick position: up to a position plus one full quotient and a carry
	localparam int PICK_W = $clog2(2 * MAX_DIM + 1);
	// remainder plus remainder step
	localparam int SUM_W  = POS_W + 1;

	// register field widths
	localparam int CFG_DIM_W = 13;
	localparam int CFG_IVL_W = 8;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FRAME_IVL  = 3'd4;

	localparam logic [CFG_DIM_W-1:0] SRC_WIDTH_RST  = 13'd640;
	localparam logic [CFG_DIM_W-1:0] SRC_HEIGHT_RST = 13'd480;
	localparam logic [CFG_DIM_W-1:0] DST_WIDTH_RST  = 13'd320;
	localparam logic [CFG_DIM_W-1:0] DST_HEIGHT_RST = 13'd240;
	localparam logic [CFG_IVL_W-1:0] FRAME_IVL_RST  = 8'd4;

	// Q0.16 luma weights, summing to 65536
	localparam logic [15:0] WEIGHT_B = 16'd7471;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_R = 16'd19595;

	// short queue between classifier and luma back end
	localparam int QUEUE_DEPTH = 4;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic [7:0] gray;
		logic       row_end;
		logic       frame_end;
	} luma_t;

	// queue entry: picked pixel with its marks
	typedef struct packed {
		pix_t pix;
		logic row_end;
		logic frame_end;
	} qent_t;

	// clamped geometry and exact step ratios
	typedef struct packed {
		logic [DIM_W-1:0]     w;
		logic [DIM_W-1:0]     h;
		logic [DIM_W-1:0]     dw;
		logic [DIM_W-1:0]     dh;
		logic [CFG_IVL_W-1:0] ivl;
		logic [DIM_W-1:0]     col_quo;
		logic [POS_W-1:0]     col_rem;
		logic [DIM_W-1:0]     row_quo;
		logic [POS_W-1:0]     row_rem;
	} geom_t;

	typedef struct packed {
		logic [PICK_W-1:0] pick;
		logic [POS_W-1:0]  rem;
	} pick_step_t;

	// clamp a register dimension to 1..hi
	function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DIM_W-1:0] v,
		logic [DIM_W-1:0] hi);
		logic [31:0] v32;
		logic [DIM_W-1:0] res;
		v32 = 32'(v);
		if (v32 == 32'd0) begin
			res = DIM_W'(1);
		end else if (v32 > 32'(hi)) begin
			res = hi;
		end else begin
			res = DIM_W'(v32);
		end
		return res;
	endfunction

	// advance a pick position by quo + rem/d
	function automatic pick_step_t step_pick(logic [PICK_W-1:0] pick,
		logic [POS_W-1:0] acc, logic [DIM_W-1:0] quo, logic [POS_W-1:0] rem,
		logic [DIM_W-1:0] d);
		logic [SUM_W-1:0] sum;
		logic             carry;
		pick_step_t       res;
		sum   = SUM_W'(acc) + SUM_W'(rem);
		carry = (sum >= SUM_W'(d));
		res.rem  = carry ? POS_W'(sum - SUM_W'(d)) : POS_W'(sum);
		res.pick = pick + PICK_W'(quo) + PICK_W'(carry);
		return res;
	endfunction

endpackage

// ===== sv/ndg_div.sv =====
// ----------------------------------------------------------------------------
// ndg_div: serial unsigned divider
// Restoring divider, one quotient bit per cycle, for the source/destination
// step ratios.
// ----------------------------------------------------------------------------
module ndg_div import ndg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIM_W-1:0] dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             busy,
	output logic [DIM_W-1:0] quotient,
	output logic [POS_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DIM_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIM_W-1:0] num_q;
	logic [DIM_W-1:0] den_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] quo_q;

	logic [DIM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[DIM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIM_W-2:0], 1'b0};
			rem_q <= fits ? DIM_W'(trial - {1'b0, den_q}) : DIM_W'(trial);
			quo_q <= {quo_q[DIM_W-2:0], fits};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = POS_W'(rem_q);

endmodule

// ===== sv/ndg_front.sv =====
// ----------------------------------------------------------------------------
// ndg_front: raster counters and pick classifier
// Tracks source and destination positions, decides which source pixels are
// picked in processed frames and pushes them into the queue.
// ----------------------------------------------------------------------------
module ndg_front import ndg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  geom_t geom,
	input  logic  hold,
	input  logic  in_valid,
	input  pix_t  in_pix,
	output logic  in_stall,
	input  logic  q_full,
	output logic  q_push,
	output qent_t q_data
);

	logic [POS_W-1:0]     src_col_q, src_row_q;
	logic [DIM_W-1:0]     dst_col_q, dst_row_q;
	logic [POS_W-1:0]     col_acc_q, row_acc_q;
	logic [PICK_W-1:0]    pick_col_q, pick_row_q;
	logic [CFG_IVL_W-1:0] phase_q;

	logic                 accept;
	logic                 row_picked;
	logic                 col_hit;
	logic                 emit;
	logic                 row_end;
	logic                 frame_end;
	logic [DIM_W-1:0]     col_inc;
	logic [DIM_W-1:0]     row_inc;
	logic                 col_wrap;
	logic                 row_wrap;
	logic [CFG_IVL_W:0]   phase_inc;
	pick_step_t           col_step;
	pick_step_t           row_step;

	assign in_stall = hold | q_full;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		row_picked = (PICK_W'(src_row_q) == pick_row_q) && (dst_row_q < geom.dh);
		col_hit    = row_picked && (PICK_W'(src_col_q) == pick_col_q)
			&& (dst_col_q < geom.dw);
		emit       = col_hit && (phase_q == '0);
		row_end    = (dst_col_q == geom.dw - 1'b1);
		frame_end  = row_end && (dst_row_q == geom.dh - 1'b1);
		col_inc    = DIM_W'(src_col_q) + 1'b1;
		row_inc    = DIM_W'(src_row_q) + 1'b1;
		col_wrap   = (col_inc >= geom.w);
		row_wrap   = (row_inc >= geom.h);
		phase_inc  = {1'b0, phase_q} + 1'b1;
		col_step   = step_pick(pick_col_q, col_acc_q, geom.col_quo, geom.col_rem, geom.dw);
		row_step   = step_pick(pick_row_q, row_acc_q, geom.row_quo, geom.row_rem, geom.dh);
	end

	assign q_push           = accept & emit;
	assign q_data.pix       = in_pix;
	assign q_data.row_end   = row_end;
	assign q_data.frame_end = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			dst_col_q  <= '0;
			dst_row_q  <= '0;
			col_acc_q  <= '0;
			row_acc_q  <= '0;
			pick_col_q <= '0;
			pick_row_q <= '0;
			phase_q    <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				// line done: restart column stepping
				src_col_q  <= '0;
				dst_col_q  <= '0;
				col_acc_q  <= '0;
				pick_col_q <= '0;
				if (row_wrap) begin
					src_row_q  <= '0;
					dst_row_q  <= '0;
					row_acc_q  <= '0;
					pick_row_q <= '0;
					phase_q    <= (phase_inc >= {1'b0, geom.ivl}) ? '0
						: CFG_IVL_W'(phase_inc);
				end else begin
					src_row_q <= POS_W'(row_inc);
					if (row_picked) begin
						dst_row_q  <= dst_row_q + 1'b1;
						row_acc_q  <= row_step.rem;
						pick_row_q <= row_step.pick;
					end
				end
			end else begin
				src_col_q <= POS_W'(col_inc);
				if (col_hit) begin
					dst_col_q  <= dst_col_q + 1'b1;
					col_acc_q  <= col_step.rem;
					pick_col_q <= col_step.pick;
				end
			end
		end
	end

endmodule

// ===== sv/ndg_fifo.sv =====
// ----------------------------------------------------------------------------
// ndg_fifo: pick queue
// Small register queue that decouples the classifier from the luma back end.
// ----------------------------------------------------------------------------
module ndg_fifo import ndg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t wdata,
	output logic  full,
	input  logic  pop,
	output qent_t rdata,
	output logic  empty
);

	qent_t             mem_q [QUEUE_DEPTH];
	logic [QIDX_W-1:0] wr_ptr_q;
	logic [QIDX_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/ndg_back.sv =====
// ----------------------------------------------------------------------------
// ndg_back: luma back end
// Weighted sum of the picked BGR pixel in two stages: a product register and the output register.
// ----------------------------------------------------------------------------
module ndg_back import ndg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  qent_t q_data,
	output logic  q_pop,
	output logic  out_valid,
	output luma_t out_data,
	input  logic  out_stall
);

	localparam int PROD_W = 24;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_b_s1, prod_g_s1, prod_r_s1;
	logic              row_end_s1, frame_end_s1;

	logic              out_valid_q;
	luma_t             out_q;

	logic              out_free;
	logic              adv_s1;
	logic [PROD_W-1:0] sum;

	assign out_free = ~out_valid_q | ~out_stall;
	assign adv_s1   = ~valid_s1 | out_free;
	assign q_pop    = ~q_empty & adv_s1;
	assign sum      = prod_b_s1 + prod_g_s1 + prod_r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= ~q_empty;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_b_s1    <= PROD_W'(q_data.pix.blue) * PROD_W'(WEIGHT_B);
			prod_g_s1    <= PROD_W'(q_data.pix.green) * PROD_W'(WEIGHT_G);
			prod_r_s1    <= PROD_W'(q_data.pix.red) * PROD_W'(WEIGHT_R);
			row_end_s1   <= q_data.row_end;
			frame_end_s1 <= q_data.frame_end;
		end
		if (out_free && valid_s1) begin
			// weights sum to 1.0, so the top byte is the gray value
			out_q.gray      <= sum[PROD_W-1:16];
			out_q.row_end   <= row_end_s1;
			out_q.frame_end <= frame_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== sv/nearest_downscale_to_gray.sv =====
// ----------------------------------------------------------------------------
// nearest_downscale_to_gray: nearest-neighbor downscaler with gray output
// Picks source pixels of every frame_interval-th frame on an exact rational
// grid and emits their 8-bit luma from Q0.16 weights with end-of-row and end-of-frame marks.
// ----------------------------------------------------------------------------
// Source pixels enter one per clock in raster order while src_stall is low; a
// picked pixel passes through the pick queue, the product stage and the output
// register before it leaves as a gray value. The column and row step ratios
// W/Dw and H/Dh come from serial dividers that rerun after reset and after every
// register write; src_stall is high while they run. Beyond that the input only
// stalls when the four-entry pick queue is full.
module nearest_downscale_to_gray import ndg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// source pixels
	input  logic               src_valid,
	output logic               src_stall,
	input  pix_t               src_pix,
	// gray results
	output logic               dst_valid,
	input  logic               dst_stall,
	output luma_t              dst_pix,
	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CFG_DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [CFG_IVL_W-1:0] frame_ivl_q;
	logic                 start_q;
	logic                 wr_en;
	logic [2:0]           reg_idx;

	geom_t                geom;
	logic                 col_busy, row_busy;
	logic [DIM_W-1:0]     col_quo, row_quo;
	logic [POS_W-1:0]     col_rem, row_rem;

	logic                 q_push, q_pop, q_full, q_empty;
	qent_t                q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			dst_width_q  <= DST_WIDTH_RST;
			dst_height_q <= DST_HEIGHT_RST;
			frame_ivl_q  <= FRAME_IVL_RST;
			start_q      <= 1'b1;
		end else begin
			// recompute step ratios after any write
			start_q <= wr_en;
			if (wr_en) begin
				case (reg_idx)
					REG_SRC_WIDTH:  src_width_q  <= pwdata[CFG_DIM_W-1:0];
					REG_SRC_HEIGHT: src_height_q <= pwdata[CFG_DIM_W-1:0];
					REG_DST_WIDTH:  dst_width_q  <= pwdata[CFG_DIM_W-1:0];
					REG_DST_HEIGHT: dst_height_q <= pwdata[CFG_DIM_W-1:0];
					REG_FRAME_IVL:  frame_ivl_q  <= pwdata[CFG_IVL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
			REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_q);
			REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_q);
			REG_FRAME_IVL:  prdata = PDATA_W'(frame_ivl_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		geom.w       = clamp_dim(src_width_q, DIM_W'(MAX_DIM));
		geom.h       = clamp_dim(src_height_q, DIM_W'(MAX_DIM));
		geom.dw      = clamp_dim(dst_width_q, geom.w);
		geom.dh      = clamp_dim(dst_height_q, geom.h);
		geom.ivl     = (frame_ivl_q == '0) ? CFG_IVL_W'(1) : frame_ivl_q;
		geom.col_quo = col_quo;
		geom.col_rem = col_rem;
		geom.row_quo = row_quo;
		geom.row_rem = row_rem;
	end

	ndg_div u_col_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (geom.w),
		.divisor   (geom.dw),
		.busy      (col_busy),
		.quotient  (col_quo),
		.remainder (col_rem)
	);

	ndg_div u_row_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (geom.h),
		.divisor   (geom.dh),
		.busy      (row_busy),
		.quotient  (row_quo),
		.remainder (row_rem)
	);

	ndg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.hold     (start_q | col_busy | row_busy),
		.in_valid (src_valid),
		.in_pix   (src_pix),
		.in_stall (src_stall),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	ndg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	ndg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (dst_valid),
		.out_data  (dst_pix),
		.out_stall (dst_stall)
	);

endmodule

// ===== test/nearest_downscale_to_gray_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_downscale_to_gray_tb: self-checking bench for the gray downscaler
// Streams BGR pixels through a source port with random idle gaps, predicts every
// picked gray value with its row and frame marks, and checks each output
// transfer in order. Geometry and frame interval change between phases over
// the register port, including clamped, zero and mid-frame settings.
// ----------------------------------------------------------------------------
module nearest_downscale_to_gray_tb;
	import ndg_pkg::*;

	localparam int unsigned LUMA_B        = 7471;
	localparam int unsigned LUMA_G        = 38470;
	localparam int unsigned LUMA_R        = 19595;
	localparam int unsigned RANDOM_PIXELS = 750;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned HOLD_CYCLES   = 150;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	pix_t               src_pix = '0;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	luma_t              dst_pix;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// stimulus and expected gray values
	pix_t        pixel_queue[$];
	luma_t       luma_expected[$];
	luma_t       luma_want;

	// register copies, stored as written (masked to field width)
	int unsigned cfg_w, cfg_h, cfg_dw, cfg_dh, cfg_ivl;

	// downscaler position state
	int unsigned s_col, s_row, d_col, d_row;
	int unsigned c_rem, r_rem, pick_col, pick_row;
	int unsigned frame_slot;

	int unsigned pix_count     = 0;
	int unsigned gray_checked  = 0;
	int unsigned reg_writes    = 0;
	int unsigned frames_seen   = 0;
	int unsigned error_count   = 0;
	int unsigned pressure_mark = 32'hFFFF_FFFF;
	int unsigned hold_left     = 0;
	logic        held          = 1'b0;
	logic        calm;

	nearest_downscale_to_gray DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_pix  (src_pix),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_pix  (dst_pix),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// no random idling on either side for a stretch of the stream
	assign calm = (pix_count >= 400) && (pix_count < 520);

	task automatic flag_error(input string what);
		error_count++;
		$display("ERROR %0t: %s", $time, what);
	endtask

	function automatic int unsigned fit(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// exact rational step: pick += s/d with the remainder carried
	function automatic void step_grid(inout int unsigned pick, inout int unsigned rem,
		input int unsigned s, input int unsigned d);
		rem  += s % d;
		pick += s / d;
		if (rem >= d) begin
			rem -= d;
			pick++;
		end
	endfunction

	task automatic predict_luma(input pix_t p);
		int unsigned w, h, dw, dh, ivl, sum;
		logic        on_row;
		luma_t       res;
		w   = fit(cfg_w, 1, MAX_DIM);
		h   = fit(cfg_h, 1, MAX_DIM);
		dw  = fit(cfg_dw, 1, w);
		dh  = fit(cfg_dh, 1, h);
		ivl = (cfg_ivl == 0) ? 1 : cfg_ivl;
		on_row = (s_row == pick_row) && (d_row < dh);
		if (on_row && s_col == pick_col && d_col < dw) begin
			if (frame_slot == 0) begin
				sum = (LUMA_B * p.blue + LUMA_G * p.green + LUMA_R * p.red) >> 16;
				res.gray      = sum[7:0];
				res.row_end   = (d_col == dw - 1);
				res.frame_end = res.row_end && (d_row == dh - 1);
				luma_expected.push_back(res);
			end
			d_col++;
			step_grid(pick_col, c_rem, w, dw);
		end
		s_col++;
		if (s_col >= w) begin
			s_col    = 0;
			d_col    = 0;
			c_rem    = 0;
			pick_col = 0;
			if (on_row) begin
				d_row++;
				step_grid(pick_row, r_rem, h, dh);
			end
			s_row++;
			if (s_row >= h) begin
				s_row    = 0;
				d_row    = 0;
				r_rem    = 0;
				pick_row = 0;
				frames_seen++;
				frame_slot = (frame_slot + 1 >= ivl) ? 0 : frame_slot + 1;
			end
		end
	endtask

	// source side: present queued pixels, idle at random, hold while stalled
	always @(posedge clk) begin
		if (src_valid && !src_stall) begin
			predict_luma(src_pix);
			pix_count <= pix_count + 1;
		end
		if (!src_valid || !src_stall) begin
			if (pixel_queue.size() != 0 && (calm || $urandom_range(99, 0) >= 26)) begin
				src_valid <= 1'b1;
				src_pix   <= pixel_queue.pop_front();
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// result side: random stalls plus one long hold-off to back up the block
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dst_stall <= 1'b1;
		end else if (!held && pix_count >= pressure_mark) begin
			held      <= 1'b1;
			hold_left <= HOLD_CYCLES;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= calm ? 1'b0 : ($urandom_range(99, 0) < 26);
		end
	end

	always @(posedge clk) begin
		if (dst_valid && !dst_stall) begin
			if (luma_expected.size() == 0) begin
				flag_error($sformatf("gray transfer %0d with nothing expected", dst_pix.gray));
			end else begin
				luma_want = luma_expected.pop_front();
				gray_checked++;
				if (dst_pix.gray !== luma_want.gray)
					flag_error($sformatf("gray %0d, expected %0d", dst_pix.gray,
						luma_want.gray));
				if (dst_pix.row_end !== luma_want.row_end)
					flag_error($sformatf("row_end %b, expected %b", dst_pix.row_end,
						luma_want.row_end));
				if (dst_pix.frame_end !== luma_want.frame_end)
					flag_error($sformatf("frame_end %b, expected %b", dst_pix.frame_end,
						luma_want.frame_end));
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// write one register, read it back, and update the local copy
	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] stored;
		stored = value & ((idx == REG_FRAME_IVL) ? 32'h0000_00FF : 32'h0000_1FFF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:  cfg_w   = stored;
			REG_SRC_HEIGHT: cfg_h   = stored;
			REG_DST_WIDTH:  cfg_dw  = stored;
			REG_DST_HEIGHT: cfg_dh  = stored;
			default:        cfg_ivl = stored;
		endcase
		reg_writes++;
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== stored)
			flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata, stored));
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_geometry(input logic [31:0] w, input logic [31:0] h,
		input logic [31:0] dw, input logic [31:0] dh, input logic [31:0] ivl);
		set_reg(REG_SRC_WIDTH, w);
		set_reg(REG_SRC_HEIGHT, h);
		set_reg(REG_DST_WIDTH, dw);
		set_reg(REG_DST_HEIGHT, dh);
		set_reg(REG_FRAME_IVL, ivl);
	endtask

	// wait for the stream to drain and the block to go quiet
	task automatic settle();
		while (pixel_queue.size() != 0 || src_valid || luma_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic pix_t rand_pixel();
		pix_t p;
		if ($urandom_range(99, 0) < 12) begin
			p.blue  = $urandom_range(1, 0) ? 8'hFF : 8'h00;
			p.green = $urandom_range(1, 0) ? 8'hFF : 8'h00;
			p.red   = $urandom_range(1, 0) ? 8'hFF : 8'h00;
		end else begin
			p = pix_t'($urandom);
		end
		return p;
	endfunction

	task automatic push_random(input int unsigned n);
		repeat (n) pixel_queue.push_back(rand_pixel());
	endtask

	function automatic logic [31:0] rand_src_dim(input int unsigned typical);
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 80) return $urandom_range(typical, 1);
		if (r < 86) return 0;
		if (r < 93) return $urandom_range(8191, 4096);
		return $urandom;
	endfunction

	function automatic logic [31:0] rand_dst_dim(input int unsigned src);
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 75) return $urandom_range(fit(src, 1, MAX_DIM), 1);
		if (r < 85) return $urandom_range(16, 1);
		if (r < 92) return 0;
		return 8191;
	endfunction

	function automatic logic [31:0] rand_interval();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 50) return 1;
		if (r < 75) return $urandom_range(3, 2);
		if (r < 85) return 0;
		if (r < 93) return $urandom_range(255, 4);
		return $urandom;
	endfunction

	initial begin : stimulus
		int unsigned fed, n, area;
		logic        pressure_done;
		cfg_w   = SRC_WIDTH_RST;
		cfg_h   = SRC_HEIGHT_RST;
		cfg_dw  = DST_WIDTH_RST;
		cfg_dh  = DST_HEIGHT_RST;
		cfg_ivl = FRAME_IVL_RST;
		s_col = 0; s_row = 0; d_col = 0; d_row = 0;
		c_rem = 0; r_rem = 0; pick_col = 0; pick_row = 0;
		frame_slot = 0;
		fed = 0;
		pressure_done = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: 640x480 to 320x240, first frame processed
		pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF});
		pixel_queue.push_back({8'h00, 8'h00, 8'h00});
		pixel_queue.push_back({8'hFF, 8'h00, 8'h00});
		pixel_queue.push_back({8'h00, 8'hFF, 8'hFF});
		settle();

		// shrink mid-frame, interval zero processes every frame
		set_geometry(4, 2, 4, 2, 0);
		pixel_queue.push_back({8'h00, 8'hFF, 8'h00});
		pixel_queue.push_back({8'h00, 8'h00, 8'hFF});
		pixel_queue.push_back({8'h55, 8'h55, 8'h55});
		pixel_queue.push_back({8'hAA, 8'hAA, 8'hAA});
		pixel_queue.push_back({8'h80, 8'h80, 8'h7F});
		pixel_queue.push_back({8'h7F, 8'h80, 8'h80});
		pixel_queue.push_back({8'h01, 8'h02, 8'h03});
		pixel_queue.push_back({8'hFE, 8'hFD, 8'hFC});
		settle();

		// zero sizes clamp up to one pixel, upscale requests saturate
		set_geometry(0, 0, 8191, 8191, 1);
		pixel_queue.push_back({8'hFF, 8'hFF, 8'hFF});
		pixel_queue.push_back({8'h00, 8'h00, 8'h00});
		pixel_queue.push_back({8'h12, 8'h34, 8'h56});
		settle();

		// lower the interval while the phase sits beyond it
		set_reg(REG_FRAME_IVL, 5);
		push_random(3);
		settle();
		set_reg(REG_FRAME_IVL, 2);
		push_random(3);
		settle();

		// oversized source clamps to the largest frame, partial row only
		set_geometry(8191, 8191, 3, 2, 255);
		push_random(5);
		settle();

		while (fed < RANDOM_PIXELS) begin
			if (!pressure_done && fed >= 200) begin
				// every pixel picked while the result side holds off
				set_geometry(4, 4, 4, 4, 1);
				pressure_mark = pix_count + 4;
				n = 48;
				pressure_done = 1'b1;
			end else begin
				if ($urandom_range(99, 0) < 60) set_reg(REG_SRC_WIDTH, rand_src_dim(12));
				if ($urandom_range(99, 0) < 60) set_reg(REG_SRC_HEIGHT, rand_src_dim(8));
				if ($urandom_range(99, 0) < 60) set_reg(REG_DST_WIDTH, rand_dst_dim(cfg_w));
				if ($urandom_range(99, 0) < 60) set_reg(REG_DST_HEIGHT, rand_dst_dim(cfg_h));
				if ($urandom_range(99, 0) < 40) set_reg(REG_FRAME_IVL, rand_interval());
				area = fit(cfg_w, 1, MAX_DIM) * fit(cfg_h, 1, MAX_DIM);
				if (area <= 120 && $urandom_range(99, 0) < 70)
					n = fit(area * $urandom_range(3, 1), 1, 150);
				else
					n = $urandom_range(40, 1);
			end
			push_random(n);
			fed += n;
			settle();
		end

		$display("Covered %0d pixel transfers over %0d source frames, %0d gray results checked",
			pix_count, frames_seen, gray_checked);
		$display("Register writes: %0d, geometry and interval varied between phases",
			reg_writes);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
